// ----- rtl/apps_pkg.sv -----
// Shared types, constants and helper functions for the armed pulse pattern sequencer.
// No dependencies; every other file in rtl/ imports this package.
package apps_pkg;

    localparam int TIME_BITS    = 24;
    localparam int TBL_DEPTH    = 256;
    localparam int TBL_AW       = 8;
    localparam int POS_BITS     = 9;
    localparam int MASK_BITS    = 4;
    localparam int DUR_BITS     = 24;
    localparam int ENTRY_BITS   = MASK_BITS + DUR_BITS;
    localparam int DRV_BITS     = 14;
    localparam int CFG_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CMD_BITS     = 3;
    localparam int KIND_BITS    = 2;
    localparam int STAT_BITS    = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK       = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_SET_REPEAT = 3'd2,
        CMD_RUN        = 3'd3,
        CMD_ARM        = 3'd4,
        CMD_STOP       = 3'd5,
        CMD_HARD_RESET = 3'd6,
        CMD_GET_TIME   = 3'd7
    } cmd_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_DRIVE = 2'd0,
        KIND_TIME  = 2'd1,
        KIND_FIRE  = 2'd2
    } kind_t;

    typedef enum logic [STAT_BITS-1:0] {
        RUN_INIT      = 3'd0,
        RUN_READY     = 3'd1,
        RUN_PENDING   = 3'd2,
        RUN_RUNNING   = 3'd3,
        RUN_REPEATING = 3'd4
    } run_status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FINAL_POS   = 2'd0,
        CFG_REPEAT_FROM = 2'd1,
        CFG_FIRE_THR    = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic step;   // item accepted: apply it to the state
        logic load;   // move the pending result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_result;  // the item at the input produces a result
    } dp_stat_t;

    // a is at or ahead of b on the wrapping timebase
    function automatic logic is_future(input logic [TIME_BITS-1:0] a,
                                       input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] diff;
        diff = a - b;
        return ~diff[TIME_BITS-1];
    endfunction

    // Logical outputs 0..3 land on board bits 0, 9, 12, 13
    function automatic logic [DRV_BITS-1:0] remap_mask(input logic [MASK_BITS-1:0] m);
        logic [DRV_BITS-1:0] r;
        r     = '0;
        r[0]  = m[0];
        r[9]  = m[1];
        r[12] = m[2];
        r[13] = m[3];
        return r;
    endfunction

endpackage

// ----- rtl/apps_ctrl.sv -----
// Handshake controller for the pulse pattern sequencer: input accept, result load, output valid.
// Depends on apps_pkg.
module apps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  apps_pkg::dp_stat_t  stat,
    output apps_pkg::ctrl_cmd_t cmd
);
    import apps_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;
    logic       accept;

    assign slot_free = ~out_valid_reg | out_ready;
    assign accept    = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && stat.has_result)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.step = 1'b0;
        cmd.load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            S_LOAD:
            begin
                cmd.load = slot_free;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/apps_dpath.sv -----
// Datapath of the pulse pattern sequencer: pattern table, run state, config and result registers.
// Depends on apps_pkg.
module apps_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apps_pkg::ctrl_cmd_t                 cmd_ctl,
    output apps_pkg::dp_stat_t                  stat,
    input  logic                                cfg_write,
    input  logic [apps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [apps_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic [apps_pkg::CMD_BITS-1:0]       cmd,
    input  logic [apps_pkg::TIME_BITS-1:0]      now,
    input  logic                                driver_ready,
    input  logic [apps_pkg::TBL_AW-1:0]         entry_addr,
    input  logic [apps_pkg::MASK_BITS-1:0]      entry_mask,
    input  logic [apps_pkg::DUR_BITS-1:0]       entry_duration,
    input  logic                                repeat_enable,
    input  logic [apps_pkg::TIME_BITS-1:0]      proposed_fire,
    output logic [apps_pkg::KIND_BITS-1:0]      kind,
    output logic [apps_pkg::DUR_BITS-1:0]       drive_duration,
    output logic [apps_pkg::DRV_BITS-1:0]       drive_mask,
    output logic [apps_pkg::TIME_BITS-1:0]      time_value,
    output logic                                fire_accepted,
    output logic [apps_pkg::STAT_BITS-1:0]      run_status
);
    import apps_pkg::*;

    // Run state
    run_status_t            status_reg, status_next;
    logic [POS_BITS-1:0]    position_reg, position_next;
    logic                   rep_req_reg, rep_req_next;
    logic [TIME_BITS-1:0]   armed_reg, armed_next;

    // Configuration
    logic [CFG_BITS-1:0]    final_pos_reg;
    logic [CFG_BITS-1:0]    repeat_from_reg;
    logic [CFG_BITS-1:0]    fire_thr_reg;

    // Pattern table
    logic [ENTRY_BITS-1:0]  tbl_mem [TBL_DEPTH];
    logic [ENTRY_BITS-1:0]  rd_data_reg;
    logic                   tbl_we;
    logic                   tbl_re;
    logic [TBL_AW-1:0]      rd_addr;

    // Result waiting for the output register
    kind_t                  pend_kind_reg, pend_kind_next;
    logic [TIME_BITS-1:0]   pend_tval_reg, pend_tval_next;
    logic                   pend_acc_reg, pend_acc_next;
    run_status_t            pend_stat_reg;
    logic                   pend_drive_reg, pend_drive_next;

    // Output register
    kind_t                  out_kind_reg;
    logic [DUR_BITS-1:0]    out_dur_reg;
    logic [DRV_BITS-1:0]    out_mask_reg;
    logic [TIME_BITS-1:0]   out_tval_reg;
    logic                   out_acc_reg;
    run_status_t            out_stat_reg;

    cmd_t                   cmd_in;
    logic                   arm_start;
    logic [TIME_BITS-1:0]   lead_time;
    run_status_t            st_tick;
    logic [POS_BITS-1:0]    pos_tick;
    logic                   has_result;

    assign cmd_in    = cmd_t'(cmd);
    assign lead_time = now + {{(TIME_BITS-CFG_BITS){1'b0}}, fire_thr_reg};
    assign arm_start = (status_reg == RUN_PENDING) && is_future(armed_reg, now)
                       && is_future(lead_time, armed_reg);
    assign st_tick   = arm_start ? RUN_RUNNING : status_reg;
    assign pos_tick  = arm_start ? '0 : position_reg;
    assign rd_addr   = pos_tick[TBL_AW-1:0];

    always_comb
    begin
        status_next     = status_reg;
        position_next   = position_reg;
        rep_req_next    = rep_req_reg;
        armed_next      = armed_reg;
        pend_kind_next  = KIND_TIME;
        pend_tval_next  = now;
        pend_acc_next   = 1'b0;
        pend_drive_next = 1'b0;
        has_result      = 1'b0;
        tbl_we          = 1'b0;
        tbl_re          = 1'b0;
        unique case (cmd_in)
            CMD_TICK:
            begin
                status_next    = st_tick;
                position_next  = pos_tick;
                pend_kind_next = KIND_DRIVE;
                pend_tval_next = '0;
                if (arm_start)
                begin
                    armed_next = '0;
                end
                if ((st_tick == RUN_RUNNING || st_tick == RUN_REPEATING) && driver_ready)
                begin
                    if (pos_tick <= {1'b0, final_pos_reg})
                    begin
                        // drive the entry at the current position
                        tbl_re          = cmd_ctl.step;
                        pend_drive_next = 1'b1;
                        has_result      = 1'b1;
                        position_next   = pos_tick + 1'b1;
                    end
                    else if (st_tick == RUN_REPEATING)
                    begin
                        position_next = {1'b0, repeat_from_reg};
                    end
                    else if (rep_req_reg)
                    begin
                        status_next   = RUN_REPEATING;
                        position_next = {1'b0, repeat_from_reg};
                        rep_req_next  = 1'b0;
                    end
                    else
                    begin
                        status_next   = RUN_READY;
                        position_next = '0;
                    end
                end
            end
            CMD_WRITE:
            begin
                tbl_we = cmd_ctl.step;
            end
            CMD_SET_REPEAT:
            begin
                rep_req_next = repeat_enable;
            end
            CMD_RUN:
            begin
                status_next   = RUN_RUNNING;
                position_next = '0;
                has_result    = 1'b1;
            end
            CMD_ARM:
            begin
                pend_kind_next = KIND_FIRE;
                has_result     = 1'b1;
                if (is_future(proposed_fire, now))
                begin
                    armed_next    = proposed_fire;
                    status_next   = RUN_PENDING;
                    pend_acc_next = 1'b1;
                end
            end
            CMD_STOP:
            begin
                status_next   = RUN_READY;
                position_next = '0;
                rep_req_next  = 1'b0;
                armed_next    = '0;
            end
            CMD_HARD_RESET:
            begin
                status_next   = RUN_INIT;
                position_next = '0;
            end
            CMD_GET_TIME:
            begin
                has_result = 1'b1;
            end
        endcase
    end

    assign stat.has_result = has_result;

    // Run state: advance only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= RUN_INIT;
            position_reg <= '0;
            rep_req_reg  <= 1'b0;
            armed_reg    <= '0;
        end
        else if (cmd_ctl.step)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            rep_req_reg  <= rep_req_next;
            armed_reg    <= armed_next;
        end
    end

    // Configuration registers; index 3 is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_pos_reg   <= '0;
            repeat_from_reg <= '0;
            fire_thr_reg    <= CFG_BITS'(3);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FINAL_POS:   final_pos_reg   <= cfg_data;
                CFG_REPEAT_FROM: repeat_from_reg <= cfg_data;
                CFG_FIRE_THR:    fire_thr_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pattern table: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[entry_addr] <= {entry_mask, entry_duration};
        end
        if (tbl_re)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.step)
        begin
            pend_kind_reg  <= pend_kind_next;
            pend_tval_reg  <= pend_tval_next;
            pend_acc_reg   <= pend_acc_next;
            pend_stat_reg  <= status_next;
            pend_drive_reg <= pend_drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ctl.load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_tval_reg <= pend_tval_reg;
            out_acc_reg  <= pend_acc_reg;
            out_stat_reg <= pend_stat_reg;
            if (pend_drive_reg)
            begin
                out_dur_reg  <= rd_data_reg[DUR_BITS-1:0];
                out_mask_reg <= remap_mask(rd_data_reg[ENTRY_BITS-1:DUR_BITS]);
            end
            else
            begin
                out_dur_reg  <= '0;
                out_mask_reg <= '0;
            end
        end
    end

    assign kind           = out_kind_reg;
    assign drive_duration = out_dur_reg;
    assign drive_mask     = out_mask_reg;
    assign time_value     = out_tval_reg;
    assign fire_accepted  = out_acc_reg;
    assign run_status     = out_stat_reg;

endmodule

// ----- rtl/armed_pulse_pattern_sequencer_unit.sv -----
// Top level of the armed pulse pattern sequencer: controller plus datapath.
// Depends on apps_pkg, apps_ctrl and apps_dpath.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------------------------
//  input     in_valid / in_ready     cmd, now, driver_ready, entry_addr, entry_mask,
//                                    entry_duration, repeat_enable, proposed_fire
//  output    out_valid / out_ready   kind, drive_duration, drive_mask, time_value,
//                                    fire_accepted, run_status
//  config    cfg_write (no wait)     cfg_index, cfg_data
//
// An item without a result needs only its accept cycle; an item with a result also
// takes a load step: the accept cycle updates the run state and reads the pattern
// table; the load step then loads the output register from the registered table data.
// rst_n clears the run state, the config registers (fire threshold to 3) and the
// output valid; the pattern table holds garbage until written.
// A full output register stalls the load step, and in_ready stays low while it waits;
// once loaded, the next item is taken while the result still waits for out_ready.
module armed_pulse_pattern_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [apps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [apps_pkg::CFG_BITS-1:0]       cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [apps_pkg::CMD_BITS-1:0]       cmd,
    input  logic [apps_pkg::TIME_BITS-1:0]      now,
    input  logic                                driver_ready,
    input  logic [apps_pkg::TBL_AW-1:0]         entry_addr,
    input  logic [apps_pkg::MASK_BITS-1:0]      entry_mask,
    input  logic [apps_pkg::DUR_BITS-1:0]       entry_duration,
    input  logic                                repeat_enable,
    input  logic [apps_pkg::TIME_BITS-1:0]      proposed_fire,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [apps_pkg::KIND_BITS-1:0]      kind,
    output logic [apps_pkg::DUR_BITS-1:0]       drive_duration,
    output logic [apps_pkg::DRV_BITS-1:0]       drive_mask,
    output logic [apps_pkg::TIME_BITS-1:0]      time_value,
    output logic                                fire_accepted,
    output logic [apps_pkg::STAT_BITS-1:0]      run_status
);
    import apps_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  dp_stat;

    // Controller: accept items, hold a result until the output slot frees up
    apps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (ctl)
    );

    // Datapath: command decode, timebase compares, table and result registers
    apps_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_ctl        (ctl),
        .stat           (dp_stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .now            (now),
        .driver_ready   (driver_ready),
        .entry_addr     (entry_addr),
        .entry_mask     (entry_mask),
        .entry_duration (entry_duration),
        .repeat_enable  (repeat_enable),
        .proposed_fire  (proposed_fire),
        .kind           (kind),
        .drive_duration (drive_duration),
        .drive_mask     (drive_mask),
        .time_value     (time_value),
        .fire_accepted  (fire_accepted),
        .run_status     (run_status)
    );

endmodule
